// ===== rtl/core/plg_pkg.sv =====
// peak limiter gain: shared widths, constants, register codes and types
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package plg_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 16;
  localparam int GAIN_BITS   = COEF_BITS + 1;
  localparam int THR_BITS    = SAMPLE_BITS - 1;
  localparam int MCAND_BITS  = SAMPLE_BITS + 1;
  localparam int RND_BITS    = SAMPLE_BITS + 2;
  localparam int MUL_STEPS   = GAIN_BITS;
  localparam int DIV_STEPS   = COEF_BITS;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1) << COEF_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_MIN   = GAIN_BITS'(1);

  localparam logic signed [RND_BITS-1:0] SAT_MAX = RND_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RND_BITS-1:0] SAT_MIN = -RND_BITS'(1 << (SAMPLE_BITS - 1));

  localparam logic [1:0] REG_ATTACK    = 2'd0;
  localparam logic [1:0] REG_RELEASE   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [COEF_BITS-1:0] attack_coef;
    logic [COEF_BITS-1:0] release_coef;
    logic [THR_BITS-1:0]  threshold_level;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV,
    ST_DIV_GO,
    ST_DIV,
    ST_MUL_GO,
    ST_MUL,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/core/plg_regs.sv =====
// peak limiter gain: apb configuration registers
// depends on plg_pkg
`timescale 1ns / 1ps

module plg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [plg_pkg::DATA_BITS-1:0] pwdata,
  output logic [plg_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output plg_pkg::cfg_t                 cfg_o
);

  plg_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    idx;
  logic          wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        plg_pkg::REG_ATTACK:    cfg_d.attack_coef     = pwdata[plg_pkg::COEF_BITS-1:0];
        plg_pkg::REG_RELEASE:   cfg_d.release_coef    = pwdata[plg_pkg::COEF_BITS-1:0];
        plg_pkg::REG_THRESHOLD: cfg_d.threshold_level = pwdata[plg_pkg::THR_BITS-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      plg_pkg::REG_ATTACK:
        prdata = plg_pkg::DATA_BITS'(cfg_q.attack_coef);
      plg_pkg::REG_RELEASE:
        prdata = plg_pkg::DATA_BITS'(cfg_q.release_coef);
      plg_pkg::REG_THRESHOLD:
        prdata = plg_pkg::DATA_BITS'(cfg_q.threshold_level);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/plg_mul.sv =====
// peak limiter gain: bit-serial signed shift-add multiplier, lsb of multiplier first
// returns the product rounded half up at the q16 point; depends on plg_pkg
`timescale 1ns / 1ps

module plg_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [plg_pkg::MCAND_BITS-1:0] mcand_i,
  input  logic [plg_pkg::GAIN_BITS-1:0]         mplier_i,
  output logic                                  done_o,
  output logic signed [plg_pkg::RND_BITS-1:0]   rnd_o
);

  localparam int CntBits = $clog2(plg_pkg::MUL_STEPS);

  logic signed [plg_pkg::MCAND_BITS-1:0] mcand_q;
  logic signed [plg_pkg::MCAND_BITS-1:0] acc_q;
  logic [plg_pkg::GAIN_BITS-1:0]         mplier_q;
  logic [plg_pkg::GAIN_BITS-1:0]         lo_q;
  logic [CntBits-1:0]                    cnt_q;
  logic                                  busy_q, done_q;
  logic signed [plg_pkg::RND_BITS-1:0]   sum;
  logic                                  last;

  assign sum  = {acc_q[plg_pkg::MCAND_BITS-1], acc_q}
              + (mplier_q[0] ? {mcand_q[plg_pkg::MCAND_BITS-1], mcand_q} : '0);
  assign last = (cnt_q == CntBits'(plg_pkg::MUL_STEPS - 1));

  // floor((p + 2^15) / 2^16) with p = acc * 2^17 + lo
  assign rnd_o  = $signed({acc_q, lo_q[plg_pkg::GAIN_BITS-1]})
                + $signed({{(plg_pkg::RND_BITS-1){1'b0}}, lo_q[plg_pkg::GAIN_BITS-2]});
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntBits'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
      lo_q     <= '0;
    end else if (busy_q) begin
      acc_q    <= sum[plg_pkg::RND_BITS-1:1];
      lo_q     <= {sum[0], lo_q[plg_pkg::GAIN_BITS-1:1]};
      mplier_q <= mplier_q >> 1;
    end
  end

endmodule

// ===== rtl/core/plg_div.sv =====
// peak limiter gain: restoring divider, one quotient bit per cycle
// gain = clamp((threshold << 16) / envelope, 1, unity); depends on plg_pkg
`timescale 1ns / 1ps

module plg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [plg_pkg::THR_BITS-1:0]  thr_i,
  input  logic [plg_pkg::SAMPLE_BITS-1:0] env_i,
  output logic                          done_o,
  output logic [plg_pkg::GAIN_BITS-1:0] gain_o
);

  localparam int CntBits = $clog2(plg_pkg::DIV_STEPS);

  logic [plg_pkg::SAMPLE_BITS-1:0] rem_q, den_q;
  logic [plg_pkg::COEF_BITS-1:0]   quo_q, quo_next;
  logic [plg_pkg::GAIN_BITS-1:0]   gain_q;
  logic [CntBits-1:0]              cnt_q;
  logic                            busy_q, done_q;
  logic [plg_pkg::SAMPLE_BITS:0]   shifted;
  logic                            ge, last, saturate;

  assign shifted  = {rem_q, 1'b0};
  assign ge       = (shifted >= {1'b0, den_q});
  assign quo_next = {quo_q[plg_pkg::COEF_BITS-2:0], ge};
  assign last     = (cnt_q == CntBits'(plg_pkg::DIV_STEPS - 1));
  // zero envelope or threshold at or above it: quotient reaches unity
  assign saturate = (env_i == '0) || ({1'b0, thr_i} >= env_i);

  assign done_o = done_q;
  assign gain_o = gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= (start_i && saturate) || (busy_q && last);
      if (start_i) begin
        busy_q <= !saturate;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntBits'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= plg_pkg::SAMPLE_BITS'(thr_i);
      den_q  <= env_i;
      quo_q  <= '0;
      gain_q <= plg_pkg::GAIN_UNITY;
    end else if (busy_q) begin
      rem_q <= ge ? plg_pkg::SAMPLE_BITS'(shifted - {1'b0, den_q})
                  : shifted[plg_pkg::SAMPLE_BITS-1:0];
      quo_q <= quo_next;
      if (last) begin
        gain_q <= (quo_next == '0) ? plg_pkg::GAIN_MIN : {1'b0, quo_next};
      end
    end
  end

endmodule

// ===== rtl/core/peak_limiter_gain.sv =====
// peak limiter gain: top level, sequencer, envelope state and output register
// depends on plg_pkg, plg_regs, plg_mul, plg_div
//
//   channel  handshake               payload
//   in       in_valid_i/in_ready_o   sample_in_i
//   out      out_valid_o/out_ready_i sample_out_o, gain_applied_o
//   cfg      psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// one word at a time: the next word is taken only once the last has left emit;
// a 17-step serial multiply for the envelope step, a 16-step serial divide for the
// gain (skipped when the gain saturates at unity), a 17-step serial multiply for
// the output, plus hand-off states; the one multiplier is shared by both multiplies.
// reset clears the envelope and sets all configuration registers to all ones.
// a finished word waits in the output register while the next word is taken;
// the next word then holds in emit until the output register drains.
`timescale 1ns / 1ps

module peak_limiter_gain (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [plg_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [plg_pkg::DATA_BITS-1:0]          pwdata,
  output logic [plg_pkg::DATA_BITS-1:0]          prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [plg_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [plg_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [plg_pkg::GAIN_BITS-1:0]          gain_applied_o
);

  plg_pkg::cfg_t   cfg;
  plg_pkg::state_e state_q, state_d;

  logic signed [plg_pkg::SAMPLE_BITS-1:0] s_q, sout_q, sat;
  logic [plg_pkg::SAMPLE_BITS-1:0]        env_q, mag, diff, step, env_new;
  logic [plg_pkg::GAIN_BITS-1:0]          gain_q, gout_q;
  logic                                   rise, rise_q, out_valid_q;
  logic [plg_pkg::COEF_BITS-1:0]          coef;

  logic                                   accept, mul_start, mul_done;
  logic                                   div_start, div_done;
  logic                                   env_load, gain_load, out_load;
  logic signed [plg_pkg::MCAND_BITS-1:0]  mcand;
  logic [plg_pkg::GAIN_BITS-1:0]          mplier, div_gain;
  logic signed [plg_pkg::RND_BITS-1:0]    rnd;

  plg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  plg_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .done_o   (mul_done),
    .rnd_o    (rnd)
  );

  plg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .thr_i   (cfg.threshold_level),
    .env_i   (env_q),
    .done_o  (div_done),
    .gain_o  (div_gain)
  );

  // magnitude of the incoming word, most negative value kept exact
  assign mag  = sample_in_i[plg_pkg::SAMPLE_BITS-1] ? (~sample_in_i + 1'b1) : sample_in_i;
  assign rise = (mag > env_q);
  assign diff = rise ? (mag - env_q) : (env_q - mag);
  assign coef = rise ? cfg.attack_coef : cfg.release_coef;

  assign mcand  = (state_q == plg_pkg::ST_IDLE) ? $signed({1'b0, diff})
                                                : {s_q[plg_pkg::SAMPLE_BITS-1], s_q};
  assign mplier = (state_q == plg_pkg::ST_IDLE) ? {1'b0, coef} : gain_q;

  assign step    = rnd[plg_pkg::SAMPLE_BITS-1:0];
  assign env_new = rise_q ? (env_q + step) : (env_q - step);

  always_comb begin
    if (rnd > plg_pkg::SAT_MAX) begin
      sat = plg_pkg::SAT_MAX[plg_pkg::SAMPLE_BITS-1:0];
    end else if (rnd < plg_pkg::SAT_MIN) begin
      sat = plg_pkg::SAT_MIN[plg_pkg::SAMPLE_BITS-1:0];
    end else begin
      sat = rnd[plg_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    env_load   = 1'b0;
    gain_load  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      plg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          accept    = 1'b1;
          mul_start = 1'b1;
          state_d   = plg_pkg::ST_ENV;
        end
      end
      plg_pkg::ST_ENV: begin
        if (mul_done) begin
          env_load = 1'b1;
          state_d  = plg_pkg::ST_DIV_GO;
        end
      end
      plg_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = plg_pkg::ST_DIV;
      end
      plg_pkg::ST_DIV: begin
        if (div_done) begin
          gain_load = 1'b1;
          state_d   = plg_pkg::ST_MUL_GO;
        end
      end
      plg_pkg::ST_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = plg_pkg::ST_MUL;
      end
      plg_pkg::ST_MUL: begin
        if (mul_done) begin
          state_d = plg_pkg::ST_EMIT;
        end
      end
      plg_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = plg_pkg::ST_IDLE;
        end
      end
      default: state_d = plg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (env_load) begin
        env_q <= env_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // product of the second multiply is held while the result waits in emit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q    <= sample_in_i;
      rise_q <= rise;
    end
    if (gain_load) begin
      gain_q <= div_gain;
    end
    if (out_load) begin
      sout_q <= sat;
      gout_q <= gain_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sout_q;
  assign gain_applied_o = gout_q;

endmodule
